>>> design/assert_macros.svh
// assertion helpers, sampled on i_clk and idle while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MBAT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBAT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mbat_pkg.sv
`default_nettype none

package mbat_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 64;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // field widths
    localparam int KIND_W      = 3;
    localparam int ADDR_W      = 52;
    localparam int ADDR_MB_LSB = 20;
    localparam int MB_W        = ADDR_W - ADDR_MB_LSB;
    localparam int SEQ_W       = 32;
    localparam int BASE_W      = 19;
    localparam int SIZE_W      = 13;
    localparam int COUNT_W     = 7;
    localparam int DIV_CNT_W   = $clog2(MB_W);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SIZE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_MARK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DUMP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INC   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic mark_wr;
        logic cnt_ld;
        logic dump_rd;
        logic dump_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              div_done;
        logic              out_free;
        logic              dump_empty;
        logic              dump_last;
    } t_sts;

endpackage

`default_nettype wire

>>> design/mbat_in_if.sv
`default_nettype none

interface mbat_in_if
    import mbat_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] phys_addr;

    modport source (output valid, output kind, output phys_addr, input ready);
    modport sink   (input valid, input kind, input phys_addr, output ready);
endinterface

`default_nettype wire

>>> design/mbat_out_if.sv
`default_nettype none

interface mbat_out_if
    import mbat_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SEQ_W-1:0]  block_index;
    logic [SEQ_W-1:0]  stamp;
    logic [BASE_W-1:0] base_mb;
    logic              accessed;
    logic              out_of_range;
    logic              last;

    modport source (output valid, output block_index, output stamp, output base_mb,
                    output accessed, output out_of_range, output last, input ready);
    modport sink   (input valid, input block_index, input stamp, input base_mb,
                    input accessed, input out_of_range, input last, output ready);
endinterface

`default_nettype wire

>>> design/mbat_div.sv
`default_nettype none

module mbat_div
    import mbat_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [MB_W-1:0]   i_dividend,
    input  wire logic [SIZE_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [MB_W-1:0]        o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SIZE_W-1:0]    r_rem;
    logic [MB_W-1:0]      r_quo;

    logic [SIZE_W:0]      w_shift;
    logic [SIZE_W:0]      w_diff;
    logic                 w_ge;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        w_shift = {r_rem, r_quo[MB_W-1]};
        w_ge    = (w_shift >= {1'b0, i_divisor});
        w_diff  = w_shift - {1'b0, i_divisor};
    end

    // control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(MB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SIZE_W-1:0] : w_shift[SIZE_W-1:0];
            r_quo <= {r_quo[MB_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> design/mbat_ctrl.sv
`default_nettype none

module mbat_ctrl
    import mbat_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_DIVW = 3'd2;
    localparam logic [2:0] ST_MARK = 3'd3;
    localparam logic [2:0] ST_CNT  = 3'd4;
    localparam logic [2:0] ST_DRD  = 3'd5;
    localparam logic [2:0] ST_DWR  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = ST_DEC;
            end
            ST_DEC: begin
                priority if (i_sts.kind == KIND_MARK) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVW;
                end else if (i_sts.kind == KIND_DUMP) begin
                    n_state = i_sts.dump_empty ? ST_IDLE : ST_DRD;
                end else if (i_sts.kind == KIND_CLEAR || i_sts.kind == KIND_INC ||
                             i_sts.kind == KIND_READ) begin
                    n_state = ST_CNT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIVW: begin
                if (i_sts.div_done) n_state = ST_MARK;
            end
            ST_MARK: begin
                if (i_sts.out_free) begin
                    o_cmd.mark_wr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_CNT: begin
                if (i_sts.out_free) begin
                    o_cmd.cnt_ld = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_DRD: begin
                o_cmd.dump_rd = 1'b1;
                n_state       = ST_DWR;
            end
            ST_DWR: begin
                if (i_sts.out_free) begin
                    o_cmd.dump_out = 1'b1;
                    n_state        = i_sts.dump_last ? ST_IDLE : ST_DRD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> design/mbat_dp.sv
`default_nettype none

module mbat_dp
    import mbat_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [ADDR_W-1:0]     i_phys_addr,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    mbat_out_if.source                 o_out
);

    // configuration
    logic [SIZE_W-1:0]  r_block_size;
    logic [COUNT_W-1:0] r_block_count;
    logic [SIZE_W-1:0]  w_eff_size;
    logic [COUNT_W-1:0] w_eff_count;

    // item and state
    logic [KIND_W-1:0]  r_kind;
    logic [MB_W-1:0]    r_mb;
    logic [SEQ_W-1:0]   r_seq;
    logic [SEQ_W-1:0]   n_seq;
    logic [IDX_W-1:0]   r_ptr;

    // block table
    logic [SEQ_W-1:0]      r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;
    logic [NUM_BLOCKS-1:0] r_flag;
    logic [SEQ_W-1:0]      r_rd_data;
    logic                  r_rd_vld;
    logic                  r_rd_flag;

    // divider hookup
    logic               w_div_done;
    logic [MB_W-1:0]    w_quo;
    logic               w_oor;
    logic [IDX_W-1:0]   w_wr_addr;

    // dump values
    logic [COUNT_W-1:0]        w_dump_idx;
    logic [COUNT_W+SIZE_W-1:0] w_base_full;
    logic                      w_dump_last;

    // result register
    logic               r_out_valid;
    logic [SEQ_W-1:0]   r_out_index;
    logic [SEQ_W-1:0]   r_out_stamp;
    logic [BASE_W-1:0]  r_out_base;
    logic               r_out_acc;
    logic               r_out_oor;
    logic               r_out_last;
    logic               w_out_free;
    logic               w_out_ld;

    // zero size counts as one, count saturates at the table size
    assign w_eff_size  = (r_block_size == '0) ? SIZE_W'(1) : r_block_size;
    assign w_eff_count = (r_block_count > COUNT_W'(NUM_BLOCKS)) ? COUNT_W'(NUM_BLOCKS)
                                                                : r_block_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= SIZE_W'(1);
            r_block_count <= COUNT_W'(NUM_BLOCKS);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BLOCK_SIZE)  r_block_size  <= i_cfg_data;
            if (i_cfg_idx == CFG_BLOCK_COUNT) r_block_count <= i_cfg_data[COUNT_W-1:0];
        end
    end

    // capture the incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_mb   <= i_phys_addr[ADDR_W-1:ADDR_MB_LSB];
        end
    end

    // megabyte address over block size
    mbat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_mb),
        .i_divisor  (w_eff_size),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // quotient beyond the table means index beyond it (including wrap to zero)
    assign w_oor     = (w_quo >= MB_W'(NUM_BLOCKS));
    assign w_wr_addr = w_quo[IDX_W-1:0];

    // sequence counter operations
    always_comb begin
        unique case (r_kind)
            KIND_CLEAR: n_seq = '0;
            KIND_INC:   n_seq = r_seq + SEQ_W'(1);
            default:    n_seq = r_seq;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (i_cmd.cnt_ld) begin
            r_seq <= n_seq;
        end
    end

    // dump walk pointer
    assign w_dump_idx  = COUNT_W'(r_ptr) + COUNT_W'(1);
    assign w_dump_last = (w_dump_idx == w_eff_count);
    assign w_base_full = w_dump_idx * w_eff_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.accept) begin
            r_ptr <= '0;
        end else if (i_cmd.dump_out && !w_dump_last) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
    end

    // stamp memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_wr && !w_oor) begin
            r_mem[w_wr_addr] <= r_seq;
        end
        if (i_cmd.dump_rd) begin
            r_rd_data <= r_mem[r_ptr];
            r_rd_vld  <= r_vld[r_ptr];
            r_rd_flag <= r_flag[r_ptr];
        end
    end

    // written and accessed bits per block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_flag <= '0;
        end else begin
            if (i_cmd.mark_wr && !w_oor) begin
                r_vld[w_wr_addr]  <= 1'b1;
                r_flag[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.dump_out) begin
                r_flag[r_ptr] <= 1'b0;
            end
        end
    end

    // result register
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_out_ld   = i_cmd.mark_wr || i_cmd.cnt_ld || i_cmd.dump_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.mark_wr) begin
            r_out_index <= w_quo + SEQ_W'(1);
            r_out_stamp <= r_seq;
            r_out_base  <= '0;
            r_out_acc   <= !w_oor;
            r_out_oor   <= w_oor;
            r_out_last  <= 1'b1;
        end else if (i_cmd.cnt_ld) begin
            r_out_index <= '0;
            r_out_stamp <= n_seq;
            r_out_base  <= '0;
            r_out_acc   <= 1'b0;
            r_out_oor   <= 1'b0;
            r_out_last  <= 1'b1;
        end else if (i_cmd.dump_out) begin
            r_out_index <= SEQ_W'(w_dump_idx);
            r_out_stamp <= r_rd_vld ? r_rd_data : '0;
            r_out_base  <= w_base_full[BASE_W-1:0];
            r_out_acc   <= r_rd_flag;
            r_out_oor   <= 1'b0;
            r_out_last  <= w_dump_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.block_index  = r_out_index;
    assign o_out.stamp        = r_out_stamp;
    assign o_out.base_mb      = r_out_base;
    assign o_out.accessed     = r_out_acc;
    assign o_out.out_of_range = r_out_oor;
    assign o_out.last         = r_out_last;

    // status back to the controller
    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.div_done   = w_div_done;
        o_sts.out_free   = w_out_free;
        o_sts.dump_empty = (w_eff_count == '0);
        o_sts.dump_last  = w_dump_last;
    end

endmodule

`default_nettype wire

>>> design/memory_block_access_tracker_unit.sv
`default_nettype none
`include "assert_macros.svh"

// Tracks accesses to a table of 64 physical-memory blocks, each with an accessed flag and
// the 32-bit sequence stamp of its last access. One word is handled at a time; the
// input is ready again once the previous word's last result, if any, sits in the output
// register. A mark waits for the shift-subtract divider, which turns the megabyte address
// into a block number, before its result is loaded. A dump reads the stamp memory ahead of
// each reported block's result. Output stalls hold back the loading of any result.
// The table comes out of reset cleared through per-block flip-flop bits, so there is no
// clearing pass. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data only
// while idle; the user is bound to this, as the block itself does not enforce it.
module memory_block_access_tracker_unit
    import mbat_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mbat_in_if.sink                    i_in,
    mbat_out_if.source                 o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    // sequencing
    mbat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // table, counter, divider and result register
    mbat_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (i_in.kind),
        .i_phys_addr (i_in.phys_addr),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

    // checks
    `MBAT_ASSERT_NXT(a_busy_after_accept, i_in.valid && w_in_ready, !w_in_ready, "accepted while busy")
    `MBAT_ASSERT_IMP(a_no_overwrite, w_cmd.mark_wr || w_cmd.cnt_ld || w_cmd.dump_out, w_sts.out_free, "result overwritten")
    `MBAT_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({w_cmd.div_start, w_cmd.mark_wr, w_cmd.cnt_ld, w_cmd.dump_rd, w_cmd.dump_out}), "commands overlap")

endmodule

`default_nettype wire

>>> bench/testbench.sv
`default_nettype none

module testbench;
    import mbat_pkg::*;

    // kinds that the block ignores
    localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD_C = 3'd7;

    // a full dump reads and then reports each block in turn
    localparam int SETTLE_CYCLES = 140;
    localparam int TAIL_CYCLES   = 150;
    localparam int PHASE_WORDS   = 33;
    localparam int NUM_PHASES    = 6;

    typedef struct packed {
        logic [SEQ_W-1:0]  block_index;
        logic [SEQ_W-1:0]  stamp;
        logic [BASE_W-1:0] base_mb;
        logic              accessed;
        logic              out_of_range;
        logic              last;
    } t_blk_report;

    typedef enum logic {ROW_WORD, ROW_SETUP} t_row_op;

    typedef struct {
        t_row_op           op;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] setup_size;
        logic [COUNT_W-1:0] setup_count;
        logic              typed;
        t_blk_report       want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  take_ready = 1'b0;

    mbat_in_if  word_in ();
    mbat_out_if word_out ();

    assign word_out.ready = take_ready;

    memory_block_access_tracker_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (word_in),
        .o_out      (word_out)
    );

    always #6 i_clk = ~i_clk;

    // tracker state as the bench sees it
    logic [SIZE_W-1:0]  cfg_size  = 13'd1;
    logic [COUNT_W-1:0] cfg_count = 7'd64;
    logic [SEQ_W-1:0]   track_seq = '0;
    logic [SEQ_W-1:0]   track_stamp [NUM_BLOCKS];
    logic               track_flag  [NUM_BLOCKS];

    t_blk_report reports_due [$];
    t_stim_row   stim_rows [$];
    t_blk_report oldest_report;
    int unsigned fault_count = 0;
    bit          quiet_in    = 1'b0;
    bit          quiet_out   = 1'b0;
    int unsigned sink_hold   = 0;

    initial begin
        foreach (track_stamp[b]) begin
            track_stamp[b] = '0;
            track_flag[b]  = 1'b0;
        end
    end

    // expected reports for one accepted word, updating the tracker state
    function automatic void predict_access_reports(input logic [KIND_W-1:0] kind,
                                                   input logic [ADDR_W-1:0] addr);
        logic [SEQ_W-1:0] mb;
        logic [SEQ_W-1:0] idx;
        logic [SEQ_W-1:0] sz;
        logic [SEQ_W-1:0] n;
        t_blk_report rep;
        sz  = (cfg_size == '0) ? 32'd1 : 32'(cfg_size);
        rep = '0;
        rep.last = 1'b1;
        case (kind)
            KIND_MARK: begin
                mb  = addr[ADDR_W-1:ADDR_MB_LSB];
                idx = mb / sz + 32'd1;
                rep.block_index = idx;
                rep.stamp       = track_seq;
                if (idx == 32'd0 || idx > NUM_BLOCKS) begin
                    rep.out_of_range = 1'b1;
                end else begin
                    track_stamp[idx-1] = track_seq;
                    track_flag[idx-1]  = 1'b1;
                    rep.accessed       = 1'b1;
                end
                reports_due.push_back(rep);
            end
            KIND_DUMP: begin
                n = (cfg_count > NUM_BLOCKS) ? NUM_BLOCKS : 32'(cfg_count);
                for (int unsigned i = 1; i <= n; i++) begin
                    rep.block_index  = i;
                    rep.stamp        = track_stamp[i-1];
                    rep.base_mb      = BASE_W'(i * sz);
                    rep.accessed     = track_flag[i-1];
                    rep.out_of_range = 1'b0;
                    rep.last         = (i == n);
                    track_flag[i-1]  = 1'b0;
                    reports_due.push_back(rep);
                end
            end
            KIND_CLEAR: begin
                track_seq = '0;
                rep.stamp = track_seq;
                reports_due.push_back(rep);
            end
            KIND_INC: begin
                track_seq = track_seq + 32'd1;
                rep.stamp = track_seq;
                reports_due.push_back(rep);
            end
            KIND_READ: begin
                rep.stamp = track_seq;
                reports_due.push_back(rep);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [SEQ_W-1:0] want,
                                          input logic [SEQ_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h actual %0h", name, want, got);
            fault_count++;
        end
    endfunction

    // stimulus table helpers
    function automatic void add_word(input logic [KIND_W-1:0] kind,
                                     input logic [ADDR_W-1:0] addr);
        t_stim_row row;
        row       = '{op: ROW_WORD, default: '0};
        row.op    = ROW_WORD;
        row.kind  = kind;
        row.addr  = addr;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [KIND_W-1:0] kind,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [SEQ_W-1:0] idx, input logic [SEQ_W-1:0] stamp,
                                      input logic acc, input logic oor);
        t_stim_row row;
        row       = '{op: ROW_WORD, default: '0};
        row.op    = ROW_WORD;
        row.kind  = kind;
        row.addr  = addr;
        row.typed = 1'b1;
        row.want  = '{block_index: idx, stamp: stamp, base_mb: '0, accessed: acc,
                      out_of_range: oor, last: 1'b1};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_setup(input logic [SIZE_W-1:0] blk_sz,
                                      input logic [COUNT_W-1:0] blk_cnt);
        t_stim_row row;
        row             = '{op: ROW_SETUP, default: '0};
        row.op          = ROW_SETUP;
        row.setup_size  = blk_sz;
        row.setup_count = blk_cnt;
        stim_rows.push_back(row);
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk); while (reports_due.size() != 0);
    endtask

    // offer one word after a random gap and wait for it to be taken
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0) quiet_in = !quiet_in;
        gap = quiet_in ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            word_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word_in.valid     <= 1'b1;
        word_in.kind      <= kind;
        word_in.phys_addr <= addr;
        do @(posedge i_clk); while (!word_in.ready);
        predict_access_reports(kind, addr);
    endtask

    // registers change only with the tracker idle
    task automatic apply_block_setup(input logic [SIZE_W-1:0] blk_sz,
                                     input logic [COUNT_W-1:0] blk_cnt);
        word_in.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BLOCK_SIZE;
        i_cfg_data <= blk_sz;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BLOCK_COUNT;
        i_cfg_data <= CFG_DATA_W'(blk_cnt);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_size   = blk_sz;
        cfg_count  = blk_cnt;
    endtask

    // result side: random stalls, check each word against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            take_ready <= 1'b0;
        end else if (word_out.valid && word_out.ready) begin
            if (reports_due.size() == 0) begin
                $error("unexpected result word: block_index %0h stamp %0h",
                       word_out.block_index, word_out.stamp);
                fault_count++;
            end else begin
                oldest_report = reports_due.pop_front();
                compare_field("block_index", oldest_report.block_index, word_out.block_index);
                compare_field("stamp", oldest_report.stamp, word_out.stamp);
                compare_field("base_mb", 32'(oldest_report.base_mb), 32'(word_out.base_mb));
                compare_field("accessed", 32'(oldest_report.accessed), 32'(word_out.accessed));
                compare_field("out_of_range", 32'(oldest_report.out_of_range),
                              32'(word_out.out_of_range));
                compare_field("last", 32'(oldest_report.last), 32'(word_out.last));
            end
            if ($urandom_range(0, 15) == 0) quiet_out = !quiet_out;
            sink_hold = quiet_out ? 0 : $urandom_range(0, 5);
            take_ready <= (sink_hold == 0);
        end else if (sink_hold != 0) begin
            sink_hold--;
            take_ready <= (sink_hold == 0);
        end else begin
            take_ready <= 1'b1;
        end
    end

    // run limit
    initial begin
        #(12 * 500000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned       counted;
        int unsigned       pick;
        int unsigned       blk;
        logic [SEQ_W-1:0]  mb;
        logic [SEQ_W-1:0]  sz;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_BLOCK_SIZE;
        i_cfg_data        <= '0;
        word_in.valid     <= 1'b0;
        word_in.kind      <= KIND_READ;
        word_in.phys_addr <= '0;

        // directed words, reset setup is 1 MB blocks and 64 reported
        add_typed(KIND_READ, '0, 32'd0, 32'd0, 1'b0, 1'b0);
        add_typed(KIND_MARK, '0, 32'd1, 32'd0, 1'b1, 1'b0);
        add_typed(KIND_INC, '0, 32'd0, 32'd1, 1'b0, 1'b0);
        add_typed(KIND_MARK, (52'd63 << ADDR_MB_LSB) | 52'hFFFFF, 32'd64, 32'd1, 1'b1, 1'b0);
        add_typed(KIND_MARK, 52'd64 << ADDR_MB_LSB, 32'd65, 32'd1, 1'b0, 1'b1);
        // block number wraps to zero
        add_typed(KIND_MARK, {ADDR_W{1'b1}}, 32'd0, 32'd1, 1'b0, 1'b1);
        add_typed(KIND_INC, '0, 32'd0, 32'd2, 1'b0, 1'b0);
        add_typed(KIND_MARK, 52'd5 << ADDR_MB_LSB, 32'd6, 32'd2, 1'b1, 1'b0);
        add_word(KIND_DUMP, '0);
        add_typed(KIND_CLEAR, '0, 32'd0, 32'd0, 1'b0, 1'b0);
        add_word(KIND_RSVD_A, {ADDR_W{1'b1}});
        add_word(KIND_RSVD_C, '0);
        add_typed(KIND_INC, '0, 32'd0, 32'd1, 1'b0, 1'b0);
        // zero size acts as one, oversized count saturates
        add_setup(13'd0, 7'd127);
        add_typed(KIND_MARK, 52'd10 << ADDR_MB_LSB, 32'd11, 32'd1, 1'b1, 1'b0);
        add_word(KIND_DUMP, '0);
        // largest size, empty dump
        add_setup(13'd8191, 7'd0);
        add_typed(KIND_MARK, 52'd24573 << ADDR_MB_LSB, 32'd4, 32'd1, 1'b1, 1'b0);
        add_word(KIND_DUMP, '0);
        add_word(KIND_RSVD_B, '0);
        // largest logged base
        add_setup(13'd8191, 7'd64);
        add_word(KIND_MARK, {ADDR_W{1'b1}});
        add_word(KIND_DUMP, '0);
        // single block dump
        add_setup(13'd1, 7'd1);
        add_word(KIND_INC, '0);
        add_word(KIND_MARK, '0);
        add_word(KIND_DUMP, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[r]) begin
            if (stim_rows[r].op == ROW_SETUP) begin
                apply_block_setup(stim_rows[r].setup_size, stim_rows[r].setup_count);
            end else begin
                send_word(stim_rows[r].kind, stim_rows[r].addr);
                if (stim_rows[r].typed)
                    reports_due[reports_due.size()-1] = stim_rows[r].want;
            end
        end

        // random phases, each under its own block setup
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       apply_block_setup(13'd1, 7'd64);
                1:       apply_block_setup(13'd0, 7'd127);
                2:       apply_block_setup(13'd8191, 7'd64);
                3:       apply_block_setup(13'd4096, 7'd65);
                4:       apply_block_setup(SIZE_W'($urandom_range(1, 16)),
                                           COUNT_W'($urandom_range(0, 64)));
                default: apply_block_setup(SIZE_W'($urandom_range(0, 8191)),
                                           COUNT_W'($urandom_range(0, 127)));
            endcase
            counted = 0;
            while (counted < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                addr = '0;
                if (pick < 55) begin
                    // mark that lands on a chosen block, sometimes just past the table
                    kind = KIND_MARK;
                    sz   = (cfg_size == '0) ? 32'd1 : 32'(cfg_size);
                    blk  = ($urandom_range(0, 7) == 0) ? $urandom_range(NUM_BLOCKS, 70)
                                                       : $urandom_range(0, NUM_BLOCKS - 1);
                    mb   = blk * sz + $urandom_range(0, sz - 1);
                    addr = {mb, 20'($urandom)};
                end else if (pick < 65) begin
                    kind = KIND_MARK;
                    addr = {20'($urandom), $urandom};
                end else if (pick < 73) begin
                    kind = KIND_DUMP;
                end else if (pick < 83) begin
                    kind = KIND_INC;
                end else if (pick < 88) begin
                    kind = KIND_CLEAR;
                end else if (pick < 95) begin
                    kind = KIND_READ;
                end else begin
                    kind = KIND_W'($urandom_range(KIND_RSVD_A, KIND_RSVD_C));
                    addr = {20'($urandom), $urandom};
                end
                send_word(kind, addr);
                if (kind <= KIND_READ) counted++;
                // hold off until the tracker has answered everything
                if (counted == PHASE_WORDS / 2 || $urandom_range(0, 39) == 0) begin
                    word_in.valid <= 1'b0;
                    wait_drained();
                end
            end
        end

        word_in.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && reports_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
